// ===== hdl/dnd_pkg.sv =====
// Shared types and constants for the day number to date converter.
// No dependencies.
`timescale 1ns / 1ps

package dnd_pkg;

  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned YOFF_W    = 8;
  localparam int unsigned REM_W     = 17;
  localparam int unsigned YEAR_W    = 12;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;

  localparam logic [COUNT_W-1:0] MAX_COUNT  = 17'd73049;
  localparam logic [YEAR_W-1:0]  FIRST_YEAR = 12'd1900;
  localparam logic [8:0]         YEAR_LEN   = 9'd365;
  localparam logic [8:0]         LEAP_LEN   = 9'd366;
  localparam logic [MONTH_W-1:0] JAN        = 4'd1;
  localparam logic [MONTH_W-1:0] FEB        = 4'd2;
  localparam logic [MONTH_W-1:0] APR        = 4'd4;
  localparam logic [MONTH_W-1:0] JUN        = 4'd6;
  localparam logic [MONTH_W-1:0] SEP        = 4'd9;
  localparam logic [MONTH_W-1:0] NOV        = 4'd11;
  localparam logic [MONTH_W-1:0] DEC        = 4'd12;

  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
  } dnd_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } dnd_status_t;

  // Years run 1900..2099 only: leap when divisible by 4, except 1900.
  function automatic logic is_leap(input logic [YOFF_W-1:0] yoff);
    is_leap = (yoff[1:0] == 2'b00) && (yoff != '0);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo,
                                                 input logic leap);
    case (mo)
      APR, JUN, SEP, NOV: month_len = 5'd30;
      FEB:                month_len = leap ? 5'd29 : 5'd28;
      default:            month_len = 5'd31;
    endcase
  endfunction

endpackage

// ===== hdl/dnd_ctrl.sv =====
// Controller for the day number to date converter: sequences load, year
// and month subtraction, and the result strobe. Depends on dnd_pkg.
`timescale 1ns / 1ps

module dnd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  dnd_pkg::dnd_status_t status,
  output dnd_pkg::dnd_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import dnd_pkg::*;

  typedef enum logic [3:0] {
    IDLE   = 4'b0001,
    YEARS  = 4'b0010,
    MONTHS = 4'b0100,
    FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.year_step  = 1'b0;
    cmd.month_step = 1'b0;
    case (state)
      IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = YEARS;
        end
      end
      YEARS: begin
        if (status.year_done) begin
          state_next = MONTHS;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      MONTHS: begin
        if (status.month_done) begin
          state_next = FINISH;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      FINISH: state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != IDLE);
  assign done = (state == FINISH);

endmodule

// ===== hdl/dnd_datapath.sv =====
// Datapath for the day number to date converter: remaining days, year
// offset and month registers with their subtract steps. Depends on dnd_pkg.
`timescale 1ns / 1ps

module dnd_datapath (
  input  logic                            clk,
  input  dnd_pkg::dnd_cmd_t               cmd,
  input  logic [dnd_pkg::COUNT_W-1:0]     day_count,
  output dnd_pkg::dnd_status_t            status,
  output logic [dnd_pkg::YEAR_W-1:0]      year_out,
  output logic [dnd_pkg::MONTH_W-1:0]     month_out,
  output logic [dnd_pkg::DAY_W-1:0]       day_out
);
  import dnd_pkg::*;

  logic [REM_W-1:0]   rem;
  logic [YOFF_W-1:0]  yoff;
  logic [MONTH_W-1:0] mo;
  logic               leap;
  logic [8:0]         ylen;
  logic [DAY_W-1:0]   mlen;
  logic [REM_W-1:0]   start_rem;

  assign leap = is_leap(yoff);
  assign ylen = leap ? LEAP_LEN : YEAR_LEN;
  assign mlen = month_len(mo, leap);

  always_comb begin
    if (day_count == '0) begin
      start_rem = '0;
    end else if (day_count > MAX_COUNT) begin
      start_rem = MAX_COUNT - 17'd1;
    end else begin
      start_rem = day_count - 17'd1;
    end
  end

  assign status.year_done  = (rem < {8'd0, ylen});
  assign status.month_done = (rem < {12'd0, mlen}) || (mo >= DEC);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem  <= start_rem;
      yoff <= '0;
      mo   <= JAN;
    end else if (cmd.year_step) begin
      rem  <= rem - {8'd0, ylen};
      yoff <= yoff + 8'd1;
    end else if (cmd.month_step) begin
      rem <= rem - {12'd0, mlen};
      mo  <= mo + 4'd1;
    end
  end

  assign year_out  = FIRST_YEAR + {4'd0, yoff};
  assign month_out = mo;
  assign day_out   = rem[DAY_W-1:0] + 5'd1;

endmodule

// ===== hdl/day_number_to_date_top.sv =====
// Converts a day count (1 = 1900-01-01) into a Gregorian year, month and day,
// saturated to 1900-01-01 .. 2099-12-31. After start is taken, the date is
// presented for one cycle with done high, once the year steps and then the
// month steps are through; one year or one month is subtracted per clock.
// busy is high from the accept edge until done
// ends; the receiver must take the result in the done cycle.
// Top level; depends on dnd_pkg, dnd_ctrl, dnd_datapath.
`timescale 1ns / 1ps

module day_number_to_date_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dnd_pkg::COUNT_W-1:0] day_count,
  output logic                        busy,
  output logic                        done,
  output logic [dnd_pkg::YEAR_W-1:0]  year_out,
  output logic [dnd_pkg::MONTH_W-1:0] month_out,
  output logic [dnd_pkg::DAY_W-1:0]   day_out
);
  import dnd_pkg::*;

  dnd_cmd_t    cmd;
  dnd_status_t status;

  dnd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  dnd_datapath u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .day_count (day_count),
    .status    (status),
    .year_out  (year_out),
    .month_out (month_out),
    .day_out   (day_out)
  );

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done without busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done)) else $error("item accepted but not busy");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1
              && year_out >= 12'd1900 && year_out <= 12'd2099))
    else $error("result out of range");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for day_number_to_date_top: directed and random day counts,
// predicted dates compared field by field against each done strobe.
// Depends on dnd_pkg and day_number_to_date_top.
`timescale 1ns / 1ps

module tb;
  import dnd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned MAX_GAP     = 220;
  localparam int unsigned SETTLE      = 220;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic [COUNT_W-1:0] day_count;
  logic               busy;
  logic               done;
  logic [YEAR_W-1:0]  year_out;
  logic [MONTH_W-1:0] month_out;
  logic [DAY_W-1:0]   day_out;

  date_t       pending_dates[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned idle_pct;

  day_number_to_date_top DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .day_count (day_count),
    .busy      (busy),
    .done      (done),
    .year_out  (year_out),
    .month_out (month_out),
    .day_out   (day_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit leap_year(input int unsigned yr);
    if (yr % 400 == 0) return 1'b1;
    if (yr % 100 == 0) return 1'b0;
    return (yr % 4 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned yr,
                                             input logic [MONTH_W-1:0] mo);
    case (mo)
      APR, JUN, SEP, NOV: return 30;
      FEB:                return leap_year(yr) ? 29 : 28;
      default:            return 31;
    endcase
  endfunction

  function automatic date_t date_of_count(input logic [COUNT_W-1:0] cnt);
    int unsigned        left;
    int unsigned        yr;
    int unsigned        ylen;
    logic [MONTH_W-1:0] mo;
    date_t              d;
    left = cnt;
    if (left < 1) left = 1;
    if (left > MAX_COUNT) left = MAX_COUNT;
    left = left - 1;
    yr = FIRST_YEAR;
    ylen = leap_year(yr) ? LEAP_LEN : YEAR_LEN;
    while (left >= ylen) begin
      left = left - ylen;
      yr++;
      ylen = leap_year(yr) ? LEAP_LEN : YEAR_LEN;
    end
    mo = JAN;
    while (left >= month_days(yr, mo) && mo != DEC) begin
      left = left - month_days(yr, mo);
      mo++;
    end
    d.year  = YEAR_W'(yr);
    d.month = mo;
    d.day   = DAY_W'(left + 1);
    return d;
  endfunction

  function automatic logic [COUNT_W-1:0] random_day_count();
    case ($urandom_range(0, 9))
      0:       return COUNT_W'($urandom_range(MAX_COUNT + 1, (1 << COUNT_W) - 1));
      1:       return COUNT_W'($urandom_range(0, 3));
      2:       return COUNT_W'($urandom_range(MAX_COUNT - 3, MAX_COUNT + 3));
      default: return COUNT_W'($urandom_range(1, MAX_COUNT));
    endcase
  endfunction

  task automatic send_count(input logic [COUNT_W-1:0] cnt);
    start     <= 1'b1;
    day_count <= cnt;
    do @(posedge clk); while (busy);
    pending_dates.push_back(date_of_count(cnt));
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
  endtask

  task automatic drain_dates();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_dates();
    logic [COUNT_W-1:0] counts[$];
    counts = {17'd0, 17'd1, 17'd2, 17'd31, 17'd32, 17'd59, 17'd60, 17'd61,
              17'd365, 17'd366, 17'd1461, 17'd1462, 17'd36524, 17'd36525,
              17'd36584, 17'd36585, 17'd36890, 17'd73048, 17'd73049,
              17'd73050, 17'h1FFFF, 17'h15555, 17'h0AAAA};
    idle_pct = 0;
    foreach (counts[i]) send_count(counts[i]);
  endtask

  task automatic test_random_counts(input int unsigned n, input int unsigned pct);
    idle_pct = pct;
    repeat (n) send_count(random_day_count());
  endtask

  task automatic test_drained_restart();
    idle_pct = 0;
    repeat (5) send_count(random_day_count());
    drain_dates();
    repeat (5) send_count(random_day_count());
  endtask

  always @(posedge clk) begin
    date_t want;
    if (!rst && done) begin
      if (pending_dates.size() == 0) begin
        $error("result with no pending date: %0d-%0d-%0d", year_out, month_out, day_out);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        if (year_out !== want.year) begin
          $error("year_out: expected %0d, got %0d", want.year, year_out);
          mismatches++;
        end
        if (month_out !== want.month) begin
          $error("month_out: expected %0d, got %0d", want.month, month_out);
          mismatches++;
        end
        if (day_out !== want.day) begin
          $error("day_out: expected %0d, got %0d", want.day, day_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles     = 0;
    idle_pct   = 0;
    rst        = 1'b1;
    start      = 1'b0;
    day_count  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_dates();
    test_random_counts(200, 0);
    test_random_counts(200, 48);
    test_drained_restart();
    test_random_counts(240, 20);

    drain_dates();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
